FILE: rtl/nsag_pkg.sv
`timescale 1ns / 1ps

package nsag_pkg;

  // Fixed field widths
  localparam int unsigned ADDR_W      = 30;
  localparam int unsigned COORD_W     = 12;
  localparam int unsigned DIM_REG_W   = 13;
  localparam int unsigned PITCH_W     = 16;
  localparam int unsigned DEPTH_W     = 2;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  // Step ratios: unsigned 13.16 at the default MAX_DIM (16 fraction bits)
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned MAX_DIM_DEF = 4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DST_WIDTH   = 3'd0,
    REG_DST_HEIGHT  = 3'd1,
    REG_SRC_WIDTH   = 3'd2,
    REG_SRC_HEIGHT  = 3'd3,
    REG_SRC_PITCH   = 3'd4,
    REG_DST_PITCH   = 3'd5,
    REG_PIXEL_DEPTH = 3'd6
  } nsag_reg_e;

  typedef enum logic [DEPTH_W-1:0] {
    DEPTH_1B = 2'd0,
    DEPTH_2B = 2'd1,
    DEPTH_3B = 2'd2,
    DEPTH_4B = 2'd3
  } nsag_depth_e;

  // Controller -> datapath
  typedef struct packed {
    logic capture;
    logic div_start;
    logic div_sel_y;
    logic ld_step_x;
    logic ld_step_y;
    logic ld_mul;
    logic ld_clamp;
    logic ld_smul;
    logic ld_out;
  } nsag_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic div_done;
  } nsag_sts_t;

  // log2 of bytes per pixel for the pixel-pitch depths
  function automatic logic [1:0] bpp_shift(input logic [DEPTH_W-1:0] depth);
    logic [1:0] sh;
    case (depth) inside
      DEPTH_2B: sh = 2'd1;
      DEPTH_4B: sh = 2'd2;
      default:  sh = 2'd0;
    endcase
    return sh;
  endfunction

endpackage

FILE: rtl/nsag_intf.sv
`timescale 1ns / 1ps

interface nsag_in_if;
  import nsag_pkg::*;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface nsag_out_if;
  import nsag_pkg::*;
  logic               valid;
  logic               ready;
  logic [ADDR_W-1:0]  src_addr;
  logic [ADDR_W-1:0]  dst_addr;
  logic [COORD_W-1:0] out_col;
  logic [COORD_W-1:0] out_row;
  logic               frame_end;

  modport source (output valid, output src_addr, output dst_addr, output out_col,
                  output out_row, output frame_end, input ready);
  modport sink   (input valid, input src_addr, input dst_addr, input out_col,
                  input out_row, input frame_end, output ready);
endinterface

interface nsag_cfg_if;
  import nsag_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/nsag_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module nsag_div #(
  parameter int unsigned DIVIDEND_W = 29,
  parameter int unsigned DIVISOR_W  = 13
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic [DIVIDEND_W-1:0] quotient_o,
  output logic                  done_o
);

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] quo_q;
  logic [DIVISOR_W-1:0]  rem_q;
  logic [DIVISOR_W-1:0]  div_q;
  logic [CNT_W-1:0]      cnt_q;
  logic                  busy_q;
  logic                  done_q;

  logic [DIVISOR_W:0]    rem_sh;
  logic [DIVISOR_W:0]    rem_nx;
  logic                  ge;

  always_comb begin
    rem_sh = {rem_q, quo_q[DIVIDEND_W-1]};
    ge     = rem_sh >= {1'b0, div_q};
    rem_nx = ge ? (rem_sh - {1'b0, div_q}) : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q  <= CNT_W'(DIVIDEND_W);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
      rem_q <= rem_nx[DIVISOR_W-1:0];
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

FILE: rtl/nsag_dp.sv
`timescale 1ns / 1ps

module nsag_dp #(
  parameter int unsigned MAX_DIM = nsag_pkg::MAX_DIM_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  nsag_pkg::nsag_cmd_t             cmd_i,
  output nsag_pkg::nsag_sts_t             sts_o,
  input  logic                            cfg_we_i,
  input  logic [nsag_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [nsag_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            restart_i,
  output logic [nsag_pkg::ADDR_W-1:0]     src_addr_o,
  output logic [nsag_pkg::ADDR_W-1:0]     dst_addr_o,
  output logic [nsag_pkg::COORD_W-1:0]    out_col_o,
  output logic [nsag_pkg::COORD_W-1:0]    out_row_o,
  output logic                            frame_end_o
);
  import nsag_pkg::*;

  localparam int unsigned DW  = $clog2(MAX_DIM + 1);   // effective size
  localparam int unsigned CW  = $clog2(MAX_DIM);       // coordinate
  localparam int unsigned SW  = DW + FRAC_BITS;        // step
  localparam int unsigned PXW = CW + SW;               // coord * step
  localparam int unsigned SXW = PXW - FRAC_BITS;       // integer part
  localparam int unsigned PW  = CW + PITCH_W;          // coord * pitch
  localparam logic [SW-1:0] STEP_RST = SW'((64'd1 << FRAC_BITS) + 64'd1);

  function automatic logic [DW-1:0] eff_dim(input logic [DIM_REG_W-1:0] v);
    logic [15:0] v16;
    v16 = 16'(v);
    if (v16 == 16'd0) begin
      v16 = 16'd1;
    end else if (v16 > 16'(MAX_DIM)) begin
      v16 = 16'(MAX_DIM);
    end
    return DW'(v16);
  endfunction

  // configuration
  logic [DIM_REG_W-1:0] dst_w_q, dst_h_q, src_w_q, src_h_q;
  logic [PITCH_W-1:0]   src_pitch_q, dst_pitch_q;
  logic [DEPTH_W-1:0]   depth_q;

  // walk and pipeline
  logic [CW-1:0]     col_q, row_q;
  logic [SW-1:0]     step_x_q, step_y_q;
  logic [CW-1:0]     x_q, y_q;
  logic              fend_q;
  logic [PXW-1:0]    px_q, py_q;
  logic [ADDR_W-1:0] dline_q;
  logic [CW-1:0]     sx_q, sy_q;
  logic [ADDR_W-1:0] dst_addr_q;
  logic [ADDR_W-1:0] sline_q;

  logic [ADDR_W-1:0]  src_addr_q, dst_out_q;
  logic [COORD_W-1:0] col_out_q, row_out_q;
  logic               fend_out_q;

  logic [DW-1:0] dw, dh, sw, sh;
  assign dw = eff_dim(dst_w_q);
  assign dh = eff_dim(dst_h_q);
  assign sw = eff_dim(src_w_q);
  assign sh = eff_dim(src_h_q);

  // ---- step divider ----
  logic [SW-1:0] div_dividend;
  logic [DW-1:0] div_divisor;
  logic [SW-1:0] div_quo;
  logic          div_done;

  assign div_dividend = cmd_i.div_sel_y ? {sh, FRAC_BITS'(0)} : {sw, FRAC_BITS'(0)};
  assign div_divisor  = cmd_i.div_sel_y ? dh : dw;

  nsag_div #(
    .DIVIDEND_W (SW),
    .DIVISOR_W  (DW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quotient_o (div_quo),
    .done_o     (div_done)
  );

  assign sts_o.div_done = div_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dst_w_q     <= DIM_REG_W'(1);
      dst_h_q     <= DIM_REG_W'(1);
      src_w_q     <= DIM_REG_W'(1);
      src_h_q     <= DIM_REG_W'(1);
      src_pitch_q <= PITCH_W'(1);
      dst_pitch_q <= PITCH_W'(1);
      depth_q     <= DEPTH_1B;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_DST_WIDTH:   dst_w_q     <= cfg_data_i[DIM_REG_W-1:0];
        REG_DST_HEIGHT:  dst_h_q     <= cfg_data_i[DIM_REG_W-1:0];
        REG_SRC_WIDTH:   src_w_q     <= cfg_data_i[DIM_REG_W-1:0];
        REG_SRC_HEIGHT:  src_h_q     <= cfg_data_i[DIM_REG_W-1:0];
        REG_SRC_PITCH:   src_pitch_q <= cfg_data_i[PITCH_W-1:0];
        REG_DST_PITCH:   dst_pitch_q <= cfg_data_i[PITCH_W-1:0];
        REG_PIXEL_DEPTH: depth_q     <= cfg_data_i[DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_x_q <= STEP_RST;
      step_y_q <= STEP_RST;
    end else begin
      if (cmd_i.ld_step_x) step_x_q <= div_quo + SW'(1);
      if (cmd_i.ld_step_y) step_y_q <= div_quo + SW'(1);
    end
  end

  // ---- raster walk ----
  logic [CW-1:0] x_cap, y_cap, col_d, row_d;
  logic [CW:0]   col_inc, row_inc;
  logic          fend_d;

  always_comb begin
    x_cap   = restart_i ? '0 : col_q;
    y_cap   = restart_i ? '0 : row_q;
    col_inc = (CW+1)'(x_cap) + (CW+1)'(1);
    row_inc = (CW+1)'(y_cap) + (CW+1)'(1);
    if (col_inc >= (CW+1)'(dw)) begin
      col_d = '0;
      row_d = (row_inc >= (CW+1)'(dh)) ? '0 : row_inc[CW-1:0];
    end else begin
      col_d = col_inc[CW-1:0];
      row_d = y_cap;
    end
    fend_d = (DW'(x_cap) == (dw - DW'(1))) && (DW'(y_cap) == (dh - DW'(1)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_i.capture) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // ---- address pipeline ----
  logic [SXW-1:0]    sx_raw, sy_raw;
  logic [DW-1:0]     sw_last, sh_last;
  logic [ADDR_W-1:0] x_ext, sx_ext;
  logic [1:0]        sh_bpp;
  logic [ADDR_W-1:0] dst_addr_d, src_addr_d;

  always_comb begin
    sx_raw  = px_q[PXW-1:FRAC_BITS];
    sy_raw  = py_q[PXW-1:FRAC_BITS];
    sw_last = sw - DW'(1);
    sh_last = sh - DW'(1);
    x_ext   = ADDR_W'(x_q);
    sx_ext  = ADDR_W'(sx_q);
    sh_bpp  = bpp_shift(depth_q);
    if (depth_q == DEPTH_3B) begin
      dst_addr_d = dline_q + x_ext + (x_ext << 1);
      src_addr_d = sline_q + sx_ext + (sx_ext << 1);
    end else begin
      dst_addr_d = (dline_q + x_ext) << sh_bpp;
      src_addr_d = (sline_q + sx_ext) << sh_bpp;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      x_q    <= x_cap;
      y_q    <= y_cap;
      fend_q <= fend_d;
    end
    if (cmd_i.ld_mul) begin
      px_q    <= PXW'(x_q) * PXW'(step_x_q);
      py_q    <= PXW'(y_q) * PXW'(step_y_q);
      dline_q <= ADDR_W'(PW'(y_q) * PW'(dst_pitch_q));
    end
    if (cmd_i.ld_clamp) begin
      sx_q       <= (sx_raw > SXW'(sw_last)) ? CW'(sw_last) : CW'(sx_raw);
      sy_q       <= (sy_raw > SXW'(sh_last)) ? CW'(sh_last) : CW'(sy_raw);
      dst_addr_q <= dst_addr_d;
    end
    if (cmd_i.ld_smul) begin
      sline_q <= ADDR_W'(PW'(sy_q) * PW'(src_pitch_q));
    end
    if (cmd_i.ld_out) begin
      src_addr_q <= src_addr_d;
      dst_out_q  <= dst_addr_q;
      col_out_q  <= COORD_W'(x_q);
      row_out_q  <= COORD_W'(y_q);
      fend_out_q <= fend_q;
    end
  end

  assign src_addr_o  = src_addr_q;
  assign dst_addr_o  = dst_out_q;
  assign out_col_o   = col_out_q;
  assign out_row_o   = row_out_q;
  assign frame_end_o = fend_out_q;

endmodule

FILE: rtl/nsag_ctrl.sv
`timescale 1ns / 1ps

module nsag_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                out_ready_i,
  input  logic                cfg_valid_i,
  input  nsag_pkg::nsag_sts_t sts_i,
  output nsag_pkg::nsag_cmd_t cmd_o,
  output logic                in_ready_o,
  output logic                out_valid_o
);
  import nsag_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_STARTX = 9'b000000010,
    ST_DIVX   = 9'b000000100,
    ST_STARTY = 9'b000001000,
    ST_DIVY   = 9'b000010000,
    ST_MUL    = 9'b000100000,
    ST_CLAMP  = 9'b001000000,
    ST_SMUL   = 9'b010000000,
    ST_OUT    = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_MUL;
        end
      end
      ST_STARTX: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIVX;
      end
      ST_DIVX: begin
        if (sts_i.div_done) begin
          cmd_o.ld_step_x = 1'b1;
          state_d         = ST_STARTY;
        end
      end
      ST_STARTY: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel_y = 1'b1;
        state_d         = ST_DIVY;
      end
      ST_DIVY: begin
        if (sts_i.div_done) begin
          cmd_o.ld_step_y = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      ST_MUL: begin
        cmd_o.ld_mul = 1'b1;
        state_d      = ST_CLAMP;
      end
      ST_CLAMP: begin
        cmd_o.ld_clamp = 1'b1;
        state_d        = ST_SMUL;
      end
      ST_SMUL: begin
        cmd_o.ld_smul = 1'b1;
        state_d       = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.ld_out = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    // any register write reruns both step divisions
    if (cfg_valid_i) begin
      state_d = ST_STARTX;
    end
  end

  always_comb begin
    if (cmd_o.ld_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/nearest_scaler_address_gen.sv
`timescale 1ns / 1ps

// Nearest-neighbor scaler address generator. Each input transaction covers one
// destination pixel in raster order (restart=1 jumps back to pixel 0,0 first)
// and yields one output transaction with the byte offsets of the chosen source
// pixel and of the destination pixel, the destination column/row and a
// frame_end flag on the last pixel. Source coordinates are
// (dst_coord * step) >> 16 with step = (src_size << 16) / dst_size + 1,
// clamped to the last source column/row. Pitches count pixels for 1, 2 and
// 4 byte depths and bytes for the 3 byte depth; offsets wrap at 2^30. Between
// acceptance and the next ready an item passes capture, a multiply stage
// for coord*step and row*dst_pitch, a clamp stage, a multiply stage for
// src_row*src_pitch and the output load. The result sits in an output
// register, so the next item is taken while it waits; a stalled output holds
// the pipeline in its last stage. Every configuration write reruns the two
// step divisions on one shared radix-2 divider with a W-bit dividend,
// W = clog2(MAX_DIM+1) + 16; input ready stays low after the last write until
// both divisions are done. Configuration is always ready.

module nearest_scaler_address_gen #(
  parameter int unsigned MAX_DIM = nsag_pkg::MAX_DIM_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  nsag_in_if.sink    in_i,
  nsag_out_if.source out_o,
  nsag_cfg_if.sink   cfg_i
);
  import nsag_pkg::*;

  nsag_cmd_t cmd;
  nsag_sts_t sts;
  logic      cfg_we;

  // config writes are never back-pressured
  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid && cfg_i.ready;

  // sequencing: divider runs, per-pixel stages, output register valid
  nsag_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .out_ready_i (out_o.ready),
    .cfg_valid_i (cfg_we),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid)
  );

  // config registers, walk counters, step divider and address math
  nsag_dp #(
    .MAX_DIM (MAX_DIM)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .restart_i   (in_i.restart),
    .src_addr_o  (out_o.src_addr),
    .dst_addr_o  (out_o.dst_addr),
    .out_col_o   (out_o.out_col),
    .out_row_o   (out_o.out_row),
    .frame_end_o (out_o.frame_end)
  );

endmodule

FILE: rtl/nsag_checker.sv
`timescale 1ns / 1ps

module nsag_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         cfg_valid_i,
  input logic                         cfg_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [nsag_pkg::ADDR_W-1:0]  src_addr_i,
  input logic [nsag_pkg::ADDR_W-1:0]  dst_addr_i,
  input logic [nsag_pkg::COORD_W-1:0] out_col_i,
  input logic [nsag_pkg::COORD_W-1:0] out_row_i,
  input logic                         frame_end_i
);

  // one pixel in flight: no new transaction the cycle after one is taken
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input accepted back to back");

  // a config write starts the step divisions, which blocks input
  a_cfg_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_i) |=> !in_ready_i)
    else $error("input ready right after config write");

  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("output valid dropped while stalled");

  a_out_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      ($stable(src_addr_i) && $stable(dst_addr_i) && $stable(out_col_i) &&
       $stable(out_row_i) && $stable(frame_end_i)))
    else $error("output payload changed while stalled");

endmodule

bind nearest_scaler_address_gen nsag_checker u_nsag_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .cfg_valid_i (cfg_i.valid),
  .cfg_ready_i (cfg_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .src_addr_i  (out_o.src_addr),
  .dst_addr_i  (out_o.dst_addr),
  .out_col_i   (out_o.out_col),
  .out_row_i   (out_o.out_row),
  .frame_end_i (out_o.frame_end)
);

FILE: test/tb.sv
`timescale 1ns / 1ps

// Checks the scaler address generator pixel by pixel against a local model of
// the raster walk: a short list of hand-made rows first, then randomly shaped
// frames with random idling on both sides of the pixel path.
module tb;
  import nsag_pkg::*;

  localparam int unsigned CLK_HALF     = 5;
  localparam int unsigned RESET_CYCLES = 6;
  // Longest quiet stretch: the step divisions after a write, plus long random
  // gaps and stalls. Anything near this means the pipe is stuck.
  localparam int unsigned WATCHDOG_MAX = 4000;
  localparam int unsigned TAIL_CYCLES  = 20;   // pipe is 5 stages deep
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned STALL_PCT    = 77;
  localparam int unsigned BOTH_PCT     = 36;
  localparam int unsigned GEO_COUNT    = 10;
  localparam int unsigned GEO_ITEMS    = 60;
  localparam int unsigned CLAMP_ITEMS  = 270;
  localparam int unsigned MODE_SPAN    = 30;
  localparam int unsigned CLAMP_X_GEO  = 3;
  localparam int unsigned CLAMP_Y_GEO  = 7;
  // 257 wide against 1 source pixel: step is exactly 256, so column 256 lands
  // on source column 1 and must be pulled back to column 0.
  localparam int unsigned CLAMP_DIM    = 257;
  localparam int unsigned MAX_DIM      = MAX_DIM_DEF;
  localparam int unsigned PAD_W        = CFG_DATA_W - DIM_REG_W;
  localparam int unsigned REG_COUNT    = REG_PIXEL_DEPTH + 1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef enum logic {ROW_CFG, ROW_PIX} row_kind_e;
  typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    logic [ADDR_W-1:0]  src_addr;
    logic [ADDR_W-1:0]  dst_addr;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               frame_end;
  } pixel_addr_t;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    logic                  restart;
    logic                  pinned;   // res holds a hand-typed expectation
    pixel_addr_t           res;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  nsag_in_if  in_if ();
  nsag_out_if out_if ();
  nsag_cfg_if cfg_if ();

  nearest_scaler_address_gen u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // Shadow of the register file and the walk counters
  logic [DIM_REG_W-1:0] dst_w_q, dst_h_q, src_w_q, src_h_q;
  logic [PITCH_W-1:0]   src_pitch_q, dst_pitch_q;
  logic [DEPTH_W-1:0]   depth_q;
  int unsigned          col_cnt, row_cnt;

  pixel_addr_t pending_addrs_q[$];   // addresses owed by the block, oldest first
  int unsigned mismatch_cnt;
  int unsigned quiet_cycles;
  int unsigned snd_idle_pct;
  int unsigned rcv_stall_pct;
  logic        pin_en;
  pixel_addr_t pin_val;

  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // Sizes of 0 act as 1, sizes past MAX_DIM act as MAX_DIM
  function automatic longint unsigned used_dim(logic [DIM_REG_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  // One destination pixel of the walk; advances the counters.
  function automatic pixel_addr_t walk_pixel(logic restart);
    longint unsigned dw, dh, sw, sh, stx, sty, x, y, sx, sy, sa, da, bpp;
    pixel_addr_t px;
    dw  = used_dim(dst_w_q);
    dh  = used_dim(dst_h_q);
    sw  = used_dim(src_w_q);
    sh  = used_dim(src_h_q);
    stx = ((sw << FRAC_BITS) / dw) + 1;
    sty = ((sh << FRAC_BITS) / dh) + 1;
    if (restart) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    x  = col_cnt;
    y  = row_cnt;
    sx = (x * stx) >> FRAC_BITS;
    sy = (y * sty) >> FRAC_BITS;
    // the +1 in the step can carry one past the last source pixel
    if (sx > sw - 1) sx = sw - 1;
    if (sy > sh - 1) sy = sh - 1;
    if (depth_q == DEPTH_3B) begin
      // pitches are in bytes here
      sa = sy * src_pitch_q + sx * 3;
      da = y * dst_pitch_q + x * 3;
    end else begin
      case (depth_q)
        DEPTH_2B: bpp = 2;
        DEPTH_4B: bpp = 4;
        default:  bpp = 1;
      endcase
      sa = (sy * src_pitch_q + sx) * bpp;
      da = (y * dst_pitch_q + x) * bpp;
    end
    px.src_addr  = sa[ADDR_W-1:0];
    px.dst_addr  = da[ADDR_W-1:0];
    px.col       = x[COORD_W-1:0];
    px.row       = y[COORD_W-1:0];
    px.frame_end = (x == dw - 1) && (y == dh - 1);
    // counters past a shrunk size still wrap on the next advance
    col_cnt++;
    if (col_cnt >= dw) begin
      col_cnt = 0;
      row_cnt++;
      if (row_cnt >= dh) row_cnt = 0;
    end
    return px;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx,
                                    logic [CFG_DATA_W-1:0] d);
    case (idx)
      REG_DST_WIDTH:   dst_w_q     = d[DIM_REG_W-1:0];
      REG_DST_HEIGHT:  dst_h_q     = d[DIM_REG_W-1:0];
      REG_SRC_WIDTH:   src_w_q     = d[DIM_REG_W-1:0];
      REG_SRC_HEIGHT:  src_h_q     = d[DIM_REG_W-1:0];
      REG_SRC_PITCH:   src_pitch_q = d[PITCH_W-1:0];
      REG_DST_PITCH:   dst_pitch_q = d[PITCH_W-1:0];
      REG_PIXEL_DEPTH: depth_q     = d[DEPTH_W-1:0];
      default: ;   // unknown index: dropped
    endcase
  endfunction

  function automatic void report_mismatch(string what, pixel_addr_t want,
                                          pixel_addr_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS) begin
      $display("%0t ERROR %s", $time, what);
      $display("  exp src=%h dst=%h col=%0d row=%0d end=%b",
               want.src_addr, want.dst_addr, want.col, want.row, want.frame_end);
      $display("  got src=%h dst=%h col=%0d row=%0d end=%b",
               got.src_addr, got.dst_addr, got.col, got.row, got.frame_end);
    end
  endfunction

  function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] idx,
                                        logic [CFG_DATA_W-1:0] d);
    stim_row_t r;
    r       = '0;
    r.kind  = ROW_CFG;
    r.index = idx;
    r.data  = d;
    return r;
  endfunction

  function automatic stim_row_t pix_row(logic restart, logic pinned = 1'b0,
                                        pixel_addr_t res = '0);
    stim_row_t r;
    r         = '0;
    r.kind    = ROW_PIX;
    r.restart = restart;
    r.pinned  = pinned;
    r.res     = res;
    return r;
  endfunction

  function automatic pixel_addr_t px_at(int unsigned sa, int unsigned da,
                                        int unsigned c, int unsigned r,
                                        logic fe);
    pixel_addr_t px;
    px.src_addr  = sa[ADDR_W-1:0];
    px.dst_addr  = da[ADDR_W-1:0];
    px.col       = c[COORD_W-1:0];
    px.row       = r[COORD_W-1:0];
    px.frame_end = fe;
    return px;
  endfunction

  // Mostly small sizes so frames wrap often; now and then the edges and
  // junk in the upper data bits, which the block has to mask off.
  function automatic logic [CFG_DATA_W-1:0] rand_dim();
    logic [DIM_REG_W-1:0] v;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 70) v = $urandom_range(1, 12);
    else if (pick < 80) v = $urandom_range(13, 300);
    else if (pick < 90) begin
      case ($urandom_range(3))
        0:       v = '0;
        1:       v = MAX_DIM;
        2:       v = MAX_DIM + 1;
        default: v = '1;
      endcase
    end else v = $urandom_range(0, (1 << DIM_REG_W) - 1);
    if ($urandom_range(3) == 0) return {PAD_W'($urandom()), v};
    return {{PAD_W{1'b0}}, v};
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_pitch();
    case ($urandom_range(19))
      0:       return '0;
      1:       return 1;
      2:       return '1;
      default: return $urandom_range(0, (1 << PITCH_W) - 1);
    endcase
  endfunction

  function automatic void set_idle(idle_mode_e m);
    snd_idle_pct  = (m == IDLE_SEND) ? STALL_PCT : (m == IDLE_BOTH) ? BOTH_PCT : 0;
    rcv_stall_pct = (m == IDLE_RECV) ? STALL_PCT : (m == IDLE_BOTH) ? BOTH_PCT : 0;
  endfunction

  // Register write; the caller makes sure the pixel path is empty.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    @(negedge clk_i);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = d;
    do begin
      @(posedge clk_i);
    end while (!(cfg_if.valid && cfg_if.ready));
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  // One pixel transaction. Valid stays high on return, so back-to-back
  // pixels never drop it; a random gap drops it at a falling edge.
  task automatic send_pixel(logic restart, logic pinned, pixel_addr_t res);
    while ($urandom_range(99) < snd_idle_pct) begin
      @(negedge clk_i);
      in_if.valid = 1'b0;
    end
    @(negedge clk_i);
    in_if.valid   = 1'b1;
    in_if.restart = restart;
    pin_en        = pinned;
    pin_val       = res;
    do begin
      @(posedge clk_i);
    end while (!(in_if.valid && in_if.ready));
  endtask

  // Every pixel yields a result, so an empty queue means an idle block.
  task automatic drain_results();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (pending_addrs_q.size() != 0) @(posedge clk_i);
  endtask

  // Result side: random back-pressure per the current idle mode
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_if.ready = ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  // Everything is sampled at the rising edge. Results are popped before the
  // new pixel is pushed, so the two can never pair up.
  always @(posedge clk_i) begin : check_port
    pixel_addr_t got, want;
    logic        moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (out_if.valid && out_if.ready) begin
        moved = 1'b1;
        got = {out_if.src_addr, out_if.dst_addr, out_if.out_col, out_if.out_row,
               out_if.frame_end};
        if (pending_addrs_q.size() == 0) begin
          report_mismatch("result with nothing pending", '0, got);
        end else begin
          want = pending_addrs_q.pop_front();
          if (got !== want) report_mismatch("pixel address mismatch", want, got);
        end
      end
      if (cfg_if.valid && cfg_if.ready) begin
        moved = 1'b1;
        apply_reg(cfg_if.index, cfg_if.data);
      end
      if (in_if.valid && in_if.ready) begin
        moved = 1'b1;
        want = walk_pixel(in_if.restart);   // counters advance either way
        if (pin_en) want = pin_val;
        pending_addrs_q.push_back(want);
      end
      // watchdog: no transaction anywhere for too long
      if (moved) quiet_cycles = 0;
      else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_MAX) begin
          $display("%0t ERROR watchdog: no transaction for %0d cycles", $time,
                   quiet_cycles);
          $display("nearest_scaler_address_gen test failed");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    stim_row_t             dir_rows[$];
    logic [CFG_DATA_W-1:0] geo [REG_COUNT];
    row_kind_e             last_kind;
    int unsigned           n_items;
    logic                  clamp_run;
    logic                  restart;

    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.restart = 1'b0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = REG_DST_WIDTH;
    cfg_if.data   = '0;
    pin_en        = 1'b0;
    pin_val       = '0;
    mismatch_cnt  = 0;
    quiet_cycles  = 0;
    set_idle(IDLE_NONE);

    // register reset values: 1x1 everywhere, 1 byte pixels
    dst_w_q     = 1;
    dst_h_q     = 1;
    src_w_q     = 1;
    src_h_q     = 1;
    src_pitch_q = 1;
    dst_pitch_q = 1;
    depth_q     = DEPTH_1B;
    col_cnt     = 0;
    row_cnt     = 0;

    // ---- directed rows ----
    // out of reset: 1x1 frame, every pixel is the last one
    dir_rows.push_back(pix_row(1'b0, 1'b1, px_at(0, 0, 0, 0, 1'b1)));
    dir_rows.push_back(pix_row(1'b1, 1'b1, px_at(0, 0, 0, 0, 1'b1)));
    // write to an unmapped index changes nothing
    dir_rows.push_back(cfg_row(REG_UNUSED, '1));
    dir_rows.push_back(pix_row(1'b0, 1'b1, px_at(0, 0, 0, 0, 1'b1)));
    // largest sizes and pitches, 4 byte pixels
    dir_rows.push_back(cfg_row(REG_DST_WIDTH, MAX_DIM));
    dir_rows.push_back(cfg_row(REG_DST_HEIGHT, MAX_DIM));
    dir_rows.push_back(cfg_row(REG_SRC_WIDTH, MAX_DIM));
    dir_rows.push_back(cfg_row(REG_SRC_HEIGHT, MAX_DIM));
    dir_rows.push_back(cfg_row(REG_SRC_PITCH, '1));
    dir_rows.push_back(cfg_row(REG_DST_PITCH, '1));
    dir_rows.push_back(cfg_row(REG_PIXEL_DEPTH, DEPTH_4B));
    dir_rows.push_back(pix_row(1'b1, 1'b1, px_at(0, 0, 0, 0, 1'b0)));
    dir_rows.push_back(pix_row(1'b0, 1'b1, px_at(4, 4, 1, 0, 1'b0)));
    // out of range sizes: zero acts as 1, above MAX_DIM acts as MAX_DIM
    dir_rows.push_back(cfg_row(REG_DST_WIDTH, 0));
    dir_rows.push_back(cfg_row(REG_DST_HEIGHT, '1));
    dir_rows.push_back(cfg_row(REG_SRC_WIDTH, MAX_DIM + 1));
    dir_rows.push_back(cfg_row(REG_SRC_HEIGHT, 0));
    dir_rows.push_back(cfg_row(REG_SRC_PITCH, 3));
    dir_rows.push_back(cfg_row(REG_DST_PITCH, 0));
    dir_rows.push_back(cfg_row(REG_PIXEL_DEPTH, DEPTH_3B));
    dir_rows.push_back(pix_row(1'b1));
    dir_rows.push_back(pix_row(1'b0));
    dir_rows.push_back(pix_row(1'b0));
    // 8x8 walk, then shrink width under the column counter
    dir_rows.push_back(cfg_row(REG_DST_WIDTH, 8));
    dir_rows.push_back(cfg_row(REG_DST_HEIGHT, 8));
    dir_rows.push_back(cfg_row(REG_SRC_WIDTH, 3));
    dir_rows.push_back(cfg_row(REG_SRC_HEIGHT, 5));
    dir_rows.push_back(cfg_row(REG_SRC_PITCH, 40));
    dir_rows.push_back(cfg_row(REG_DST_PITCH, 24));
    dir_rows.push_back(cfg_row(REG_PIXEL_DEPTH, DEPTH_2B));
    dir_rows.push_back(pix_row(1'b1));
    repeat (5) dir_rows.push_back(pix_row(1'b0));
    dir_rows.push_back(cfg_row(REG_DST_WIDTH, 3));
    dir_rows.push_back(pix_row(1'b0));   // column 6 still comes out, then wraps
    dir_rows.push_back(pix_row(1'b0));
    // now shrink height under the row counter; the walk wraps to the top
    dir_rows.push_back(cfg_row(REG_DST_HEIGHT, 1));
    repeat (5) dir_rows.push_back(pix_row(1'b0));   // (1,1) and (2,1) without a frame end, then (0,0) to (2,0)

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    last_kind = ROW_PIX;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        if (last_kind != ROW_CFG) drain_results();
        write_reg(dir_rows[i].index, dir_rows[i].data);
      end else begin
        send_pixel(dir_rows[i].restart, dir_rows[i].pinned, dir_rows[i].res);
      end
      last_kind = dir_rows[i].kind;
    end

    // ---- random frames ----
    // Long unbroken walks so wraps and frame ends are hit; restarts are rare.
    // Two shapes are forced so the source clamp fires in each direction.
    for (int g = 0; g < GEO_COUNT; g++) begin
      drain_results();
      geo[REG_DST_WIDTH]   = rand_dim();
      geo[REG_DST_HEIGHT]  = rand_dim();
      geo[REG_SRC_WIDTH]   = rand_dim();
      geo[REG_SRC_HEIGHT]  = rand_dim();
      geo[REG_SRC_PITCH]   = rand_pitch();
      geo[REG_DST_PITCH]   = rand_pitch();
      geo[REG_PIXEL_DEPTH] = $urandom_range(0, (1 << CFG_DATA_W) - 1);
      clamp_run = (g == CLAMP_X_GEO) || (g == CLAMP_Y_GEO);
      if (g == CLAMP_X_GEO) begin
        geo[REG_DST_WIDTH]  = CLAMP_DIM;
        geo[REG_DST_HEIGHT] = 2;
        geo[REG_SRC_WIDTH]  = 1;
      end
      if (g == CLAMP_Y_GEO) begin
        geo[REG_DST_WIDTH]  = 1;
        geo[REG_DST_HEIGHT] = CLAMP_DIM;
        geo[REG_SRC_HEIGHT] = 1;
      end
      for (int r = REG_DST_WIDTH; r <= REG_PIXEL_DEPTH; r++)
        write_reg(CFG_IDX_W'(r), geo[r]);

      n_items = clamp_run ? CLAMP_ITEMS : GEO_ITEMS;
      for (int k = 0; k < n_items; k++) begin
        // idle mode rotates inside a frame so gaps land on every stage
        set_idle(idle_mode_e'((g + k / MODE_SPAN) % 4));
        // hold off once until the block has handed back everything
        if (g == 0 && k == GEO_ITEMS / 2) drain_results();
        if (clamp_run) restart = (k == 0);
        else restart = ($urandom_range(31) == 0);
        send_pixel(restart, 1'b0, '0);
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_addrs_q.size() == 0) begin
      $display("nearest_scaler_address_gen test passed");
    end else begin
      $display("nearest_scaler_address_gen test failed");
    end
    $finish;
  end

endmodule
